/* rtl/hed_pkg.sv */
package hed_pkg;

  localparam int unsigned MAX_ENTITY_SPAN = 10;
  localparam int unsigned IDX_W = $clog2(MAX_ENTITY_SPAN + 1);
  localparam int unsigned CP_W = 21;
  localparam int unsigned ACC_W = CP_W + 4;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SAT     = 21'h110000;
  localparam logic [CP_W-1:0] CP_SUR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SUR_HI  = 21'h00DFFF;

  typedef enum logic [3:0] {
    S_IDLE, S_BYTE, S_CLOSE, S_WS, S_SGN, S_PFX0, S_PFX1, S_PFX2,
    S_DIG, S_CHK, S_UTF, S_RAW, S_OVF, S_FLUSH, S_FIN
  } state_e;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // {valid, value}
  function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (hex && c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (hex && c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // n is byte count minus one, k the byte position
  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [1:0] n, input logic [1:0] k);
    logic [7:0] r;
    r = '0;
    if (k == 2'd0) begin
      case (n)
        2'd0: r = {1'b0, cp[6:0]};
        2'd1: r = {3'b110, cp[10:6]};
        2'd2: r = {4'b1110, cp[15:12]};
        default: r = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (2'(n - k))
        2'd0: r = {2'b10, cp[5:0]};
        2'd1: r = {2'b10, cp[11:6]};
        default: r = {2'b10, cp[17:12]};
      endcase
    end
    return r;
  endfunction

endpackage

/* rtl/html_entity_decoder.sv */
// HTML entity decoder, one text byte per input transaction.
// Input channel: in_valid_i/in_ready_o with in_byte_i and end_of_text_i.
// Output channel: out_valid_o/out_ready_i with out_byte_o, run_last_o
// (last byte caused by an input transaction) and text_done_o (last byte of
// the text). An input transaction may cause no output at all.
// A single sequencer handles one transaction at a time over a shared byte
// read port of the entity buffer; in_ready_o is high only while it is idle.
// A byte taken into an open entity with room is only stored in the entity
// buffer. A plain byte or a named entity gives one output byte. An entity sent
// back raw, or bytes flushed at end of text, go out one byte at a time. A
// numeric entity is scanned one character at a time, then sent as UTF-8 bytes.
// An entity that runs too long is rescanned at one buffered byte per cycle
// while the receiver does not stall, then flushed if the text ends.
// Output bytes go through a one-byte hold stage and the output register; a
// held byte moves on when the next byte is produced or its transaction ends.
// A stalled receiver holds the sequencer at its next output byte; the
// output register keeps its transaction until taken.
// Reset empties the entity buffer and the output stage.
module html_entity_decoder
  import hed_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       text_done_o
);

  state_e state_q, state_d;
  logic [7:0] ent_q [MAX_ENTITY_SPAN];
  logic [IDX_W-1:0] fill_q, fill_d, idx_q, idx_d;
  logic [7:0] b_q, b_d;
  logic last_q, last_d;
  logic [CP_W-1:0] v_q, v_d;
  logic neg_q, neg_d, hex_q, hex_d;
  logic [1:0] un_q, un_d;
  logic pend_valid_q, pend_valid_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  logic out_valid_q, run_last_q, text_done_q;
  logic [7:0] out_byte_q;

  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0] wr_data, cur, emit_byte, named_byte;
  logic emit_req, emit_fire, can_emit, out_free, fin_push, load_out, named;
  logic [4:0] dv;
  logic [ACC_W-1:0] acc;

  assign out_free  = !out_valid_q || out_ready_i;
  assign can_emit  = !pend_valid_q || out_free;
  assign emit_fire = emit_req && can_emit;
  assign load_out  = (emit_fire && pend_valid_q) || fin_push;
  assign in_ready_o = (state_q == S_IDLE);
  assign cur = (idx_q < IDX_W'(MAX_ENTITY_SPAN)) ? ent_q[idx_q] : b_q;
  assign dv = digit_val(cur, hex_q);

  always_comb begin
    acc = hex_q ? {v_q, 4'h0} : (ACC_W'({v_q, 3'b000}) + ACC_W'({v_q, 1'b0}));
    acc = acc + ACC_W'(dv[3:0]);
  end

  always_comb begin
    named = 1'b1;
    named_byte = CH_AMP;
    if (fill_q == IDX_W'(4) && ent_q[1] == "a" && ent_q[2] == "m" && ent_q[3] == "p")
      named_byte = CH_AMP;
    else if (fill_q == IDX_W'(3) && ent_q[1] == "l" && ent_q[2] == "t")
      named_byte = CH_LT;
    else if (fill_q == IDX_W'(3) && ent_q[1] == "g" && ent_q[2] == "t")
      named_byte = CH_GT;
    else if (fill_q == IDX_W'(5) && ent_q[1] == "q" && ent_q[2] == "u" &&
             ent_q[3] == "o" && ent_q[4] == "t")
      named_byte = CH_QUOT;
    else if (fill_q == IDX_W'(4) && ent_q[1] == "#" && ent_q[2] == "3" && ent_q[3] == "9")
      named_byte = CH_APOS;
    else if (fill_q == IDX_W'(5) && ent_q[1] == "a" && ent_q[2] == "p" &&
             ent_q[3] == "o" && ent_q[4] == "s")
      named_byte = CH_APOS;
    else if (fill_q == IDX_W'(5) && ent_q[1] == "n" && ent_q[2] == "b" &&
             ent_q[3] == "s" && ent_q[4] == "p")
      named_byte = CH_SPACE;
    else
      named = 1'b0;
  end

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    idx_d = idx_q;
    b_d = b_q;
    last_d = last_q;
    v_d = v_q;
    neg_d = neg_q;
    hex_d = hex_q;
    un_d = un_q;
    wr_en = 1'b0;
    wr_addr = fill_q;
    wr_data = cur;
    emit_req = 1'b0;
    emit_byte = cur;
    fin_push = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          b_d = in_byte_i;
          last_d = end_of_text_i;
          idx_d = '0;
          if (fill_q == '0) begin
            if (in_byte_i != CH_AMP) begin
              state_d = S_BYTE;
            end else begin
              wr_en = 1'b1;
              wr_data = in_byte_i;
              fill_d = IDX_W'(1);
              state_d = end_of_text_i ? S_FLUSH : S_IDLE;
            end
          end else if (in_byte_i == CH_SEMI) begin
            state_d = S_CLOSE;
          end else if (fill_q < IDX_W'(MAX_ENTITY_SPAN)) begin
            wr_en = 1'b1;
            wr_data = in_byte_i;
            fill_d = fill_q + 1'b1;
            state_d = end_of_text_i ? S_FLUSH : S_IDLE;
          end else begin
            fill_d = '0;
            state_d = S_OVF;
          end
        end
      end
      S_BYTE: begin
        emit_req = 1'b1;
        emit_byte = b_q;
        if (can_emit) state_d = S_FIN;
      end
      S_CLOSE: begin
        hex_d = (ent_q[2] == CH_LX) || (ent_q[2] == CH_UX);
        v_d = '0;
        neg_d = 1'b0;
        if (named) begin
          emit_req = 1'b1;
          emit_byte = named_byte;
          if (can_emit) begin
            fill_d = '0;
            state_d = S_FIN;
          end
        end else if (fill_q >= IDX_W'(3) && ent_q[1] == CH_HASH) begin
          idx_d = hex_d ? IDX_W'(3) : IDX_W'(2);
          state_d = S_WS;
        end else begin
          idx_d = '0;
          state_d = S_RAW;
        end
      end
      S_WS: begin
        if (idx_q < fill_q && is_ws(cur)) idx_d = idx_q + 1'b1;
        else state_d = S_SGN;
      end
      S_SGN: begin
        if (idx_q < fill_q && (cur == CH_PLUS || cur == CH_MINUS)) begin
          neg_d = (cur == CH_MINUS);
          idx_d = idx_q + 1'b1;
        end
        state_d = hex_q ? S_PFX0 : S_DIG;
      end
      S_PFX0: begin
        if ((5'(idx_q) + 5'd2) < 5'(fill_q) && cur == CH_ZERO) begin
          idx_d = idx_q + 1'b1;
          state_d = S_PFX1;
        end else begin
          state_d = S_DIG;
        end
      end
      S_PFX1: begin
        if (cur == CH_LX || cur == CH_UX) begin
          idx_d = idx_q + 1'b1;
          state_d = S_PFX2;
        end else begin
          state_d = S_DIG;
        end
      end
      S_PFX2: begin
        state_d = dv[4] ? S_DIG : S_CHK;
      end
      S_DIG: begin
        if (idx_q < fill_q && dv[4]) begin
          v_d = (acc > ACC_W'(CP_MAX)) ? CP_SAT : acc[CP_W-1:0];
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        idx_d = '0;
        if (!neg_q && v_q != '0 && v_q <= CP_MAX && !(v_q >= CP_SUR_LO && v_q <= CP_SUR_HI)) begin
          if (v_q < 21'h80) un_d = 2'd0;
          else if (v_q < 21'h800) un_d = 2'd1;
          else if (v_q < 21'h10000) un_d = 2'd2;
          else un_d = 2'd3;
          state_d = S_UTF;
        end else begin
          state_d = S_RAW;
        end
      end
      S_UTF: begin
        emit_req = 1'b1;
        emit_byte = utf8_byte(v_q, un_q, idx_q[1:0]);
        if (can_emit) begin
          if (idx_q[1:0] == un_q) begin
            fill_d = '0;
            state_d = S_FIN;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_RAW: begin
        emit_req = 1'b1;
        emit_byte = (idx_q < fill_q) ? cur : CH_SEMI;
        if (can_emit) begin
          if (idx_q == fill_q) begin
            fill_d = '0;
            state_d = S_FIN;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_OVF: begin
        if (idx_q == '0) begin
          emit_req = 1'b1;
          if (can_emit) idx_d = idx_q + 1'b1;
        end else begin
          if (fill_q == '0 && cur != CH_AMP) begin
            emit_req = 1'b1;
          end else begin
            wr_en = 1'b1;
            fill_d = fill_q + 1'b1;
          end
          if (!emit_req || can_emit) begin
            if (idx_q == IDX_W'(MAX_ENTITY_SPAN)) begin
              idx_d = '0;
              state_d = last_q ? S_FLUSH : S_FIN;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
        end
      end
      S_FLUSH: begin
        if (idx_q < fill_q) begin
          emit_req = 1'b1;
          if (can_emit) idx_d = idx_q + 1'b1;
        end else begin
          fill_d = '0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          fin_push = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_byte_d = pend_byte_q;
    if (emit_fire) begin
      pend_valid_d = 1'b1;
      pend_byte_d = emit_byte;
    end else if (fin_push) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      pend_valid_q <= pend_valid_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    b_q <= b_d;
    last_q <= last_d;
    v_q <= v_d;
    neg_q <= neg_d;
    hex_q <= hex_d;
    un_q <= un_d;
    pend_byte_q <= pend_byte_d;
    if (wr_en) ent_q[wr_addr] <= wr_data;
    if (load_out) begin
      out_byte_q <= pend_byte_q;
      run_last_q <= fin_push;
      text_done_q <= fin_push && last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign text_done_o = text_done_q;

  a_idle_pend_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_valid_q) else $error("hold stage busy while idle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= IDX_W'(MAX_ENTITY_SPAN)) else $error("entity fill out of range");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && text_done_o) |-> run_last_o) else $error("text_done without run_last");

  a_text_end_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && fin_push && last_q) |=> (fill_q == '0)) else $error("entity held past text end");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench
  import hed_pkg::*;
();

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       done;
  } dec_byte_t;

  typedef struct {
    logic [7:0] b;
    logic       eot;
    logic [7:0] exp_b;
    bit         typed;
  } stim_row_t;

  localparam int unsigned LIMIT_CYCLES = 400000;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       end_of_text_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       text_done_o;

  html_entity_decoder uut (.*);

  // predictor state
  logic [7:0] ent_buf [MAX_ENTITY_SPAN];
  int         ent_fill;
  dec_byte_t  decoded_q [$];
  logic [7:0] step_q [$];

  int errors;
  int mism;
  int cycles;
  int n_items;
  int n_bytes;
  int stall_left;
  bit quiet;

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int hex_digit(input logic [7:0] c, input bit hex);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (hex && c >= "a" && c <= "f") return int'(c) - 87;
    if (hex && c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit form_is(input logic [7:0] e[], input int len, input string s);
    if (s.len() != len) return 0;
    for (int i = 0; i < len; i++) if (e[i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic void close_entity();
    logic [7:0] e [];
    int         len;
    int         pos;
    int         d;
    bit         hex;
    bit         neg;
    int unsigned cp;
    len = ent_fill + 1;
    e = new[len];
    for (int i = 0; i < ent_fill; i++) e[i] = ent_buf[i];
    e[ent_fill] = CH_SEMI;
    ent_fill = 0;
    if (form_is(e, len, "&amp;"))  begin step_q.push_back(CH_AMP);   return; end
    if (form_is(e, len, "&lt;"))   begin step_q.push_back(CH_LT);    return; end
    if (form_is(e, len, "&gt;"))   begin step_q.push_back(CH_GT);    return; end
    if (form_is(e, len, "&quot;")) begin step_q.push_back(CH_QUOT);  return; end
    if (form_is(e, len, "&#39;"))  begin step_q.push_back(CH_APOS);  return; end
    if (form_is(e, len, "&apos;")) begin step_q.push_back(CH_APOS);  return; end
    if (form_is(e, len, "&nbsp;")) begin step_q.push_back(CH_SPACE); return; end
    if (len > 3 && e[1] == CH_HASH) begin
      hex = e[2] == CH_LX || e[2] == CH_UX;
      pos = hex ? 3 : 2;
      neg = 0;
      cp = 0;
      while (pos < len && is_space(e[pos])) pos++;
      if (pos < len && (e[pos] == CH_PLUS || e[pos] == CH_MINUS)) begin
        neg = e[pos] == CH_MINUS;
        pos++;
      end
      if (hex && pos + 2 < len && e[pos] == CH_ZERO && (e[pos+1] == CH_LX ||
          e[pos+1] == CH_UX) && hex_digit(e[pos+2], 1) >= 0)
        pos += 2;
      while (pos < len) begin
        d = hex_digit(e[pos], hex);
        if (d < 0) break;
        cp = cp * (hex ? 16 : 10) + d;
        if (cp > 32'h10FFFF) cp = 32'h110000;
        pos++;
      end
      if (neg) cp = 0;
      if (cp != 0 && cp <= 32'h10FFFF && !(cp >= 32'hD800 && cp <= 32'hDFFF)) begin
        if (cp < 32'h80) step_q.push_back(cp[7:0]);
        else if (cp < 32'h800) begin
          step_q.push_back(8'hC0 | cp[10:6]);
          step_q.push_back(8'h80 | cp[5:0]);
        end else if (cp < 32'h10000) begin
          step_q.push_back(8'hE0 | cp[15:12]);
          step_q.push_back(8'h80 | cp[11:6]);
          step_q.push_back(8'h80 | cp[5:0]);
        end else begin
          step_q.push_back(8'hF0 | cp[20:18]);
          step_q.push_back(8'h80 | cp[17:12]);
          step_q.push_back(8'h80 | cp[11:6]);
          step_q.push_back(8'h80 | cp[5:0]);
        end
        return;
      end
    end
    for (int i = 0; i < len; i++) step_q.push_back(e[i]);
  endfunction

  function automatic void rescan(input logic [7:0] b);
    if (ent_fill == 0 && b != CH_AMP) step_q.push_back(b);
    else if (ent_fill < MAX_ENTITY_SPAN) ent_buf[ent_fill++] = b;
    else step_q.push_back(b);
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    logic [7:0] held [MAX_ENTITY_SPAN];
    int n;
    dec_byte_t r;
    step_q.delete();
    if (ent_fill == 0) begin
      if (b == CH_AMP) ent_buf[ent_fill++] = b;
      else step_q.push_back(b);
    end else if (b == CH_SEMI) begin
      close_entity();
    end else if (ent_fill < MAX_ENTITY_SPAN) begin
      ent_buf[ent_fill++] = b;
    end else begin
      n = ent_fill;
      for (int i = 0; i < n; i++) held[i] = ent_buf[i];
      ent_fill = 0;
      step_q.push_back(held[0]);
      for (int k = 1; k < n; k++) rescan(held[k]);
      rescan(b);
    end
    if (eot) begin
      for (int k = 0; k < ent_fill; k++) step_q.push_back(ent_buf[k]);
      ent_fill = 0;
    end
    foreach (step_q[k]) begin
      r.data = step_q[k];
      r.run_end = k == step_q.size() - 1;
      r.done = r.run_end && eot;
      decoded_q.push_back(r);
    end
  endfunction

  // output side
  always @(posedge clk_i) begin
    dec_byte_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_bytes <= n_bytes + 1;
      if (decoded_q.size() == 0) begin
        errors++;
        if (mism++ < 10) $display("unexpected output byte %h", out_byte_o);
      end else begin
        e = decoded_q.pop_front();
        if (e.data !== out_byte_o || e.run_end !== run_last_o || e.done !== text_done_o)
        begin
          errors++;
          if (mism++ < 10)
            $display("mismatch: exp byte %h last %b done %b, got %h %b %b",
                     e.data, e.run_end, e.done, out_byte_o, run_last_o, text_done_o);
        end
      end
    end
  end

  // ready stalls in bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      stall_left <= 0;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send(input logic [7:0] b, input logic eot);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_byte(b, eot);
    n_items++;
  endtask

  function automatic logic [7:0] rnd_byte();
    int k;
    string pool;
    pool = "&;#xX0123456789abcdefABCDEF+- \tlgtampquosn";
    k = $urandom_range(0, 9);
    if (k < 2) return 8'($urandom_range(0, 255));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  task automatic send_str(input string s, input bit eot_end);
    for (int i = 0; i < s.len(); i++) send(s[i], eot_end && i == s.len() - 1);
  endtask

  stim_row_t rows [$];
  string forms [$];

  initial begin
    stim_row_t r;
    string s;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i = '0;
    end_of_text_i = 1'b0;
    errors = 0; mism = 0; n_items = 0; quiet = 0;
    ent_fill = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: single input bytes with known result
    r = '{8'h00, 1'b1, 8'h00, 1'b1}; rows.push_back(r);
    r = '{8'hFF, 1'b1, 8'hFF, 1'b1}; rows.push_back(r);
    r = '{8'h41, 1'b0, 8'h41, 1'b1}; rows.push_back(r);
    r = '{CH_AMP, 1'b1, CH_AMP, 1'b1}; rows.push_back(r);
    r = '{CH_SEMI, 1'b1, CH_SEMI, 1'b1}; rows.push_back(r);
    foreach (rows[i]) begin
      send(rows[i].b, rows[i].eot);
      if (rows[i].typed && (step_q.size() != 1 || step_q[0] != rows[i].exp_b)) begin
        errors++;
        if (mism++ < 10)
          $display("directed row %0d: exp byte %h, predictor gave %0d bytes",
                   i, rows[i].exp_b, step_q.size());
      end
    end
    forms = '{"&amp;", "&lt;", "&gt;", "&quot;", "&#39;", "&apos;", "&nbsp;",
              "&#x10FFFF;", "&#1114112;", "&#xD800;", "&#0;", "&#-5;", "&#X20AC;",
              "&#xx;", "&# +0x41;", "&AMP;", "&abcdefghijk", "&&&;", "&#200;x"};
    foreach (forms[i]) send_str(forms[i], i % 3 == 2);
    send(8'h7A, 1'b1);

    // random texts: mostly entity-shaped sequences
    while (n_items < 330) begin
      if (n_items > 290) quiet = 1;
      case ($urandom_range(0, 3))
        0: s = $sformatf("&#%0d;", $urandom_range(0, 1200000));
        1: s = $sformatf("&#x%0h;", $urandom_range(0, 32'h11FFFF));
        2: s = forms[$urandom_range(0, 6)];
        default: begin
          s = "";
          repeat ($urandom_range(1, 14)) s = {s, string'(rnd_byte())};
        end
      endcase
      send_str(s, $urandom_range(0, 3) == 0);
    end
    send(8'($urandom_range(0, 255)), 1'b1);
    in_valid_i <= 1'b0;
    quiet = 1;

    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("%0d input bytes sent, %0d decoded bytes checked", n_items, n_bytes);
    $display("covered named, decimal, hex, rejected and overlong entities");
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/hed_pkg.sv
rtl/html_entity_decoder.sv
sim/testbench.sv
